[src/hrp_pkg.sv]
// Shared constants and character-class functions for the HTTP request head parser.
package hrp_pkg;

  // Default width of the version accumulators.
  localparam int unsigned VersionWidthDefault = 8;

  // Status codes of a result word.
  localparam logic [1:0] ST_MORE = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // Field tags of a result word.
  localparam logic [2:0] TAG_NONE   = 3'd0;
  localparam logic [2:0] TAG_METHOD = 3'd1;
  localparam logic [2:0] TAG_URI    = 3'd2;
  localparam logic [2:0] TAG_NAME   = 3'd3;
  localparam logic [2:0] TAG_VALUE  = 3'd4;

  // Delimiter characters.
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_CTL   = 8'h1f;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_P     = 8'h50;

  // Control characters are 0..31 and DEL.
  function automatic logic is_ctl(input logic [7:0] c);
    return (c <= CH_CTL) || (c == CH_DEL);
  endfunction

  // Separators as listed for HTTP/1.x tokens.
  function automatic logic is_sep(input logic [7:0] c);
    logic r;
    case (c) inside
      8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40, 8'h2c, 8'h3b, 8'h3a, 8'h5c, 8'h22,
      8'h2f, 8'h5b, 8'h5d, 8'h3f, 8'h3d, 8'h7b, 8'h7d, 8'h20, 8'h09: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Token characters: printable ASCII that is not a separator.
  function automatic logic is_token(input logic [7:0] c);
    return !c[7] && !is_ctl(c) && !is_sep(c);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

[src/http_request_line_header_parser.sv]
// HTTP/1.x request head parser: one byte per word, tagged results.
// Each byte is accepted into the input register; its result is then held in the result register.
// Throughput: one byte per cycle while out_ready_i does not stall the result register; the
// combinational parser state transition sets this figure.
// Back-pressure stalls both stages together; a new byte is taken whenever the input register is
// empty or its byte steps into the result register.
// Reset clears both valid flags and returns the parser to method start with zeroed versions.
module http_request_line_header_parser
  import hrp_pkg::*;
#(
  parameter int unsigned VERSION_WIDTH = VersionWidthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_in_i,
  input  logic       restart_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output logic [2:0] field_tag_o,
  output logic       new_header_o,
  output logic [7:0] byte_out_o,
  output logic [7:0] version_major_o,
  output logic [7:0] version_minor_o
);

  localparam int unsigned VW = VERSION_WIDTH;
  localparam int unsigned SW = VW + 4;

  // Parser state codes.
  localparam logic [4:0] S_METHOD_START = 5'd0;
  localparam logic [4:0] S_METHOD       = 5'd1;
  localparam logic [4:0] S_URI          = 5'd2;
  localparam logic [4:0] S_H            = 5'd3;
  localparam logic [4:0] S_T1           = 5'd4;
  localparam logic [4:0] S_T2           = 5'd5;
  localparam logic [4:0] S_P            = 5'd6;
  localparam logic [4:0] S_SLASH        = 5'd7;
  localparam logic [4:0] S_MAJ_START    = 5'd8;
  localparam logic [4:0] S_MAJ          = 5'd9;
  localparam logic [4:0] S_MIN_START    = 5'd10;
  localparam logic [4:0] S_MIN          = 5'd11;
  localparam logic [4:0] S_LF1          = 5'd12;
  localparam logic [4:0] S_LINE_START   = 5'd13;
  localparam logic [4:0] S_LWS          = 5'd14;
  localparam logic [4:0] S_NAME         = 5'd15;
  localparam logic [4:0] S_SP_VALUE     = 5'd16;
  localparam logic [4:0] S_VALUE        = 5'd17;
  localparam logic [4:0] S_LF2          = 5'd18;
  localparam logic [4:0] S_LF3          = 5'd19;
  localparam logic [4:0] S_DONE         = 5'd20;
  localparam logic [4:0] S_BAD          = 5'd21;

  localparam logic [VW-1:0] VMax = {VW{1'b1}};

  // Input register stage.
  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       restart_q;

  // Parser state.
  logic [4:0]    state_q, state_d;
  logic          hseen_q, hseen_d;
  logic [VW-1:0] maj_q, maj_d;
  logic [VW-1:0] min_q, min_d;

  // Result register stage.
  logic       out_vld_q;
  logic [1:0] status_q, status_d;
  logic [2:0] tag_q, tag_d;
  logic       nh_q, nh_d;
  logic [7:0] bout_q;

  logic adv_out;
  logic step;

  assign adv_out    = !out_vld_q || out_ready_i;
  assign step       = in_vld_q && adv_out;
  assign in_ready_o = !in_vld_q || adv_out;

  // Effective state after an optional restart.
  logic [4:0]    cur_s;
  logic          cur_hs;
  logic [VW-1:0] cur_maj, cur_min;

  assign cur_s   = restart_q ? S_METHOD_START : state_q;
  assign cur_hs  = restart_q ? 1'b0 : hseen_q;
  assign cur_maj = restart_q ? '0 : maj_q;
  assign cur_min = restart_q ? '0 : min_q;

  // Decimal accumulate with saturation: acc * 10 + digit.
  logic [SW-1:0] maj_sum, min_sum;
  logic [SW-1:0] digit_ext;
  logic [VW-1:0] maj_sat, min_sat;

  assign digit_ext = {{(SW - 4){1'b0}}, 4'(byte_q - CH_ZERO)};
  assign maj_sum = ({4'b0, cur_maj} << 3) + ({4'b0, cur_maj} << 1) + digit_ext;
  assign min_sum = ({4'b0, cur_min} << 3) + ({4'b0, cur_min} << 1) + digit_ext;
  assign maj_sat = (maj_sum > {4'b0, VMax}) ? VMax : maj_sum[VW-1:0];
  assign min_sat = (min_sum > {4'b0, VMax}) ? VMax : min_sum[VW-1:0];

  // Parser transition for the byte held in the input register.
  always_comb begin
    logic bad;
    logic [7:0] c;
    c        = byte_q;
    bad      = 1'b0;
    state_d  = cur_s;
    hseen_d  = cur_hs;
    maj_d    = cur_maj;
    min_d    = cur_min;
    status_d = ST_MORE;
    tag_d    = TAG_NONE;
    nh_d     = 1'b0;
    unique case (cur_s)
      S_METHOD_START: begin
        if (is_token(c)) begin
          state_d = S_METHOD;
          tag_d   = TAG_METHOD;
        end else bad = 1'b1;
      end
      S_METHOD: begin
        if (c == CH_SP) state_d = S_URI;
        else if (is_token(c)) tag_d = TAG_METHOD;
        else bad = 1'b1;
      end
      S_URI: begin
        if (c == CH_SP) state_d = S_H;
        else if (is_ctl(c)) bad = 1'b1;
        else tag_d = TAG_URI;
      end
      S_H: begin
        if (c == CH_H) state_d = S_T1; else bad = 1'b1;
      end
      S_T1: begin
        if (c == CH_T) state_d = S_T2; else bad = 1'b1;
      end
      S_T2: begin
        if (c == CH_T) state_d = S_P; else bad = 1'b1;
      end
      S_P: begin
        if (c == CH_P) state_d = S_SLASH; else bad = 1'b1;
      end
      S_SLASH: begin
        if (c == CH_SLASH) begin
          maj_d   = '0;
          min_d   = '0;
          state_d = S_MAJ_START;
        end else bad = 1'b1;
      end
      S_MAJ_START: begin
        if (is_digit(c)) begin
          maj_d   = maj_sat;
          state_d = S_MAJ;
        end else bad = 1'b1;
      end
      S_MAJ: begin
        if (c == CH_DOT) state_d = S_MIN_START;
        else if (is_digit(c)) maj_d = maj_sat;
        else bad = 1'b1;
      end
      S_MIN_START: begin
        if (is_digit(c)) begin
          min_d   = min_sat;
          state_d = S_MIN;
        end else bad = 1'b1;
      end
      S_MIN: begin
        if (c == CH_CR) state_d = S_LF1;
        else if (is_digit(c)) min_d = min_sat;
        else bad = 1'b1;
      end
      S_LF1: begin
        if (c == CH_LF) state_d = S_LINE_START; else bad = 1'b1;
      end
      S_LINE_START: begin
        if (c == CH_CR) state_d = S_LF3;
        else if (cur_hs && (c == CH_SP || c == CH_HT)) state_d = S_LWS;
        else if (is_token(c)) begin
          hseen_d = 1'b1;
          tag_d   = TAG_NAME;
          nh_d    = 1'b1;
          state_d = S_NAME;
        end else bad = 1'b1;
      end
      S_LWS: begin
        if (c == CH_CR) state_d = S_LF2;
        else if (c == CH_SP || c == CH_HT) state_d = S_LWS;
        else if (is_ctl(c)) bad = 1'b1;
        else begin
          tag_d   = TAG_VALUE;
          state_d = S_VALUE;
        end
      end
      S_NAME: begin
        if (c == CH_COLON) state_d = S_SP_VALUE;
        else if (is_token(c)) tag_d = TAG_NAME;
        else bad = 1'b1;
      end
      S_SP_VALUE: begin
        if (c == CH_SP) state_d = S_VALUE; else bad = 1'b1;
      end
      S_VALUE: begin
        if (c == CH_CR) state_d = S_LF2;
        else if (is_ctl(c)) bad = 1'b1;
        else tag_d = TAG_VALUE;
      end
      S_LF2: begin
        if (c == CH_LF) state_d = S_LINE_START; else bad = 1'b1;
      end
      S_LF3: begin
        if (c == CH_LF) begin
          state_d  = S_DONE;
          status_d = ST_DONE;
        end else bad = 1'b1;
      end
      S_DONE: begin
        status_d = ST_DONE;
      end
      default: begin
        bad = 1'b1;
      end
    endcase
    // A malformed byte, or the held malformed state, overrides everything.
    if (bad) begin
      state_d  = S_BAD;
      status_d = ST_BAD;
      tag_d    = TAG_NONE;
      nh_d     = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= S_METHOD_START;
      hseen_q   <= 1'b0;
      maj_q     <= '0;
      min_q     <= '0;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (adv_out) out_vld_q <= in_vld_q;
      if (step) begin
        state_q <= state_d;
        hseen_q <= hseen_d;
        maj_q   <= maj_d;
        min_q   <= min_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q    <= byte_in_i;
      restart_q <= restart_i;
    end
    if (step) begin
      status_q <= status_d;
      tag_q    <= tag_d;
      nh_q     <= nh_d;
      bout_q   <= byte_q;
    end
  end

  // Version outputs carry the low byte of the accumulators.
  logic [VW+7:0] maj_ext, min_ext;
  assign maj_ext = {8'b0, maj_q};
  assign min_ext = {8'b0, min_q};

  assign out_valid_o     = out_vld_q;
  assign status_o        = status_q;
  assign field_tag_o     = tag_q;
  assign new_header_o    = nh_q;
  assign byte_out_o      = bout_q;
  assign version_major_o = maj_ext[7:0];
  assign version_minor_o = min_ext[7:0];

  // A malformed result never carries a tag or a new-header mark.
  a_bad_untagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && status_q == ST_BAD) |-> (tag_q == TAG_NONE && !nh_q))
    else $error("malformed result carries a field tag");

  // A new-header mark only goes with a header name byte.
  a_nh_is_name: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && nh_q) |-> (tag_q == TAG_NAME && status_q == ST_MORE))
    else $error("new header mark outside a header name");

  // The held malformed state answers malformed until a restart.
  a_bad_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && state_q == S_BAD && !restart_q) |=> (status_q == ST_BAD && state_q == S_BAD))
    else $error("parser left the malformed state without restart");

  // The completed head is held until a restart.
  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && state_q == S_DONE && !restart_q) |=> (status_q == ST_DONE && tag_q == TAG_NONE))
    else $error("parser left the complete state without restart");

  // Parser state moves only when a byte is stepped.
  a_state_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> $stable(state_q))
    else $error("parser state changed without a byte");

endmodule
